[hdl/gshw_pkg.sv]
// Package for the grid step-height window block: word types, register
// indexes, reset values and the controller state type.
// No dependencies; imported by the top level, the checker and the testbench.
package gshw_pkg;

    // default grid geometry and window limit
    localparam int DEF_GRID_COLS  = 256;
    localparam int DEF_GRID_ROWS  = 256;
    localparam int DEF_MAX_RADIUS = 4;

    // signed working width for coordinates, covers grids up to 4096 plus window overhang
    localparam int COORD_W = 14;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd2;

    localparam logic [2:0] RST_WINDOW_RADIUS = 3'd1;
    localparam logic [8:0] RST_GRID_WIDTH    = 9'd256;
    localparam logic [8:0] RST_GRID_HEIGHT   = 9'd256;

    // command codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
        logic               cell_known;
        logic signed [15:0] median_z;
        logic [15:0]        own_height;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  res_x;
        logic [7:0]  res_y;
        logic        res_known;
        logic [15:0] step_height;
    } out_word_t;

    // one stored cell
    typedef struct packed {
        logic               known;
        logic [15:0]        own_height;
        logic signed [15:0] median_z;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

[hdl/gshw_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gshw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/grid_step_height_window.sv]
// Grid step-height window: top level. Depends on gshw_pkg and gshw_ram.
// Write words leave busy low, so while the block is idle writes stream at one per cycle.
// Query word: the centre cell is read at accept; for a known cell with radius r>0, done
// strobes after one cell RAM read per window position; an unknown or off-grid cell, or r=0,
// answers from the centre read alone. Reset: registers return to radius 1, 256x256 grid;
// then a clearing pass over every entry zeroes its known flag, busy high throughout.
module grid_step_height_window #(
    parameter int GRID_COLS  = gshw_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS  = gshw_pkg::DEF_GRID_ROWS,
    parameter int MAX_RADIUS = gshw_pkg::DEF_MAX_RADIUS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  gshw_pkg::in_word_t                  cmd,
    output logic                                done,
    output gshw_pkg::out_word_t                 result,
    input  logic                                cfg_we,
    input  logic [gshw_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gshw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import gshw_pkg::*;

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RADW  = $clog2(MAX_RADIUS + 1);

    // configuration registers
    logic [2:0] window_radius_reg;
    logic [8:0] grid_width_reg;
    logic [8:0] grid_height_reg;

    // controller and working registers
    state_t                   state_reg, state_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic [7:0]               cx_reg, cx_next;
    logic [7:0]               cy_reg, cy_next;
    logic                     qin_reg, qin_next;
    logic [RADW-1:0]          r_reg, r_next;
    logic signed [RADW:0]     dx_reg, dx_next;
    logic signed [RADW:0]     dy_reg, dy_next;
    logic                     pend_reg, pend_next;
    logic signed [15:0]       cz_reg, cz_next;
    logic [15:0]              step_reg, step_next;
    logic                     done_reg, done_next;
    out_word_t                result_reg, result_next;

    // cell RAM port
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [CELL_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [CELL_W-1:0]        ram_rdata;
    cell_t                    rd_cell;
    cell_t                    wr_cell;

    // derived values
    logic signed [COORD_W-1:0] cols, rows;
    logic [RADW-1:0]           radius_eff;
    logic                      accept;
    logic                      cmd_inside;
    logic [AW-1:0]             cmd_addr;
    logic signed [COORD_W-1:0] nx, ny;
    logic                      nb_inside;
    logic [AW-1:0]             nb_addr;
    logic signed [RADW:0]      r_pos;
    logic signed [16:0]        diff;
    logic [16:0]               diff_mag;
    logic [15:0]               step_upd;
    logic [31:0]               cmd_addr_full;
    logic [31:0]               nb_addr_full;

    // ------------------------------------------------------------------
    // Configuration: plain write port, unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_radius_reg <= RST_WINDOW_RADIUS;
            grid_width_reg    <= RST_GRID_WIDTH;
            grid_height_reg   <= RST_GRID_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW_RADIUS: window_radius_reg <= cfg_data[2:0];
                REG_GRID_WIDTH:    grid_width_reg    <= cfg_data;
                REG_GRID_HEIGHT:   grid_height_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamp the grid in use to at least one cell and at most the built size.
    always_comb
    begin
        if (grid_width_reg == 9'd0)
            cols = COORD_W'(1);
        else if (COORD_W'(grid_width_reg) > COORD_W'(GRID_COLS))
            cols = COORD_W'(GRID_COLS);
        else
            cols = COORD_W'(grid_width_reg);

        if (grid_height_reg == 9'd0)
            rows = COORD_W'(1);
        else if (COORD_W'(grid_height_reg) > COORD_W'(GRID_ROWS))
            rows = COORD_W'(GRID_ROWS);
        else
            rows = COORD_W'(grid_height_reg);

        // radius beyond the built window acts as the largest window
        if (32'(window_radius_reg) > 32'(MAX_RADIUS))
            radius_eff = RADW'(MAX_RADIUS);
        else
            radius_eff = RADW'(window_radius_reg);
    end

    // ------------------------------------------------------------------
    // Addressing: row-major, row times a constant pitch plus column.
    // ------------------------------------------------------------------
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign cmd_inside = ($signed(COORD_W'(cmd.cell_x)) < cols)
                     && ($signed(COORD_W'(cmd.cell_y)) < rows);
    assign cmd_addr_full = 32'(cmd.cell_y) * 32'(GRID_COLS) + 32'(cmd.cell_x);
    assign cmd_addr      = cmd_addr_full[AW-1:0];

    // current neighbour in the window scan
    assign nx = $signed(COORD_W'(cx_reg)) + COORD_W'(dx_reg);
    assign ny = $signed(COORD_W'(cy_reg)) + COORD_W'(dy_reg);
    assign nb_inside = (nx >= 0) && (nx < cols) && (ny >= 0) && (ny < rows);
    assign nb_addr_full = 32'($unsigned(ny)) * 32'(GRID_COLS) + 32'($unsigned(nx));
    assign nb_addr      = nb_addr_full[AW-1:0];

    assign r_pos = $signed({1'b0, r_reg});

    // ------------------------------------------------------------------
    // Neighbour compare: a word read last cycle is folded into the running
    // maximum this cycle. The absolute difference of two 16-bit medians
    // never exceeds 65535, so no saturation stage is needed.
    // ------------------------------------------------------------------
    assign rd_cell  = cell_t'(ram_rdata);
    assign diff     = {rd_cell.median_z[15], rd_cell.median_z} - {cz_reg[15], cz_reg};
    assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);

    always_comb
    begin
        step_upd = step_reg;
        if (pend_reg && rd_cell.known && (diff_mag[15:0] > step_reg))
            step_upd = diff_mag[15:0];
    end

    // ------------------------------------------------------------------
    // RAM port selection: clearing pass, else the accepted write word.
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_cell.known      = cmd.cell_known;
        wr_cell.own_height = cmd.own_height;
        wr_cell.median_z   = cmd.median_z;

        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept && (cmd.func == FUNC_WRITE) && cmd_inside;
            ram_waddr = cmd_addr;
            ram_wdata = wr_cell;
        end

        // centre read at accept, neighbour reads while scanning
        ram_raddr = (state_reg == ST_SCAN) ? nb_addr : cmd_addr;
    end

    gshw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        qin_reg    <= qin_next;
        r_reg      <= r_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        cz_reg     <= cz_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        qin_next      = qin_reg;
        r_next        = r_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        pend_next     = 1'b0;
        cz_next       = cz_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep every entry once, known flag cleared
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (accept && (cmd.func == FUNC_QUERY))
                begin
                    cx_next    = cmd.cell_x;
                    cy_next    = cmd.cell_y;
                    qin_next   = cmd_inside;
                    r_next     = radius_eff;
                    state_next = ST_CENTRE;
                end
            end

            ST_CENTRE:
            begin
                // centre word is on the read port
                cz_next  = rd_cell.median_z;
                step_next = rd_cell.own_height;
                dx_next  = -r_pos;
                dy_next  = -r_pos;
                result_next.res_x = cx_reg;
                result_next.res_y = cy_reg;
                if (qin_reg && rd_cell.known)
                begin
                    result_next.res_known = 1'b1;
                    if (r_reg == '0)
                    begin
                        result_next.step_height = rd_cell.own_height;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    // unknown or off-grid cell answers zero
                    result_next.res_known   = 1'b0;
                    result_next.step_height = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue one neighbour read, fold the previous one
                step_next = step_upd;
                pend_next = nb_inside;
                if (dx_reg == r_pos)
                begin
                    dx_next = -r_pos;
                    if (dy_reg == r_pos)
                        state_next = ST_DRAIN;
                    else
                        dy_next = dy_reg + 1'b1;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // fold the last read and present the word
                step_next               = step_upd;
                result_next.step_height = step_upd;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/gshw_checker.sv]
// Port-level checks for the grid step-height window, attached by bind.
// Depends on gshw_pkg; binds to grid_step_height_window.
module gshw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input gshw_pkg::in_word_t   cmd,
    input logic                 done,
    input gshw_pkg::out_word_t  result
);

    import gshw_pkg::*;

    // results are single-cycle strobes and never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // a write word neither stalls nor produces a result
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func == FUNC_WRITE)) |=> (!busy && !done))
        else $error("write word stalled or produced a result");

    // a query word always occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func == FUNC_QUERY)) |=> busy)
        else $error("query word did not start work");

    // unknown cells report zero step
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.res_known) |-> (result.step_height == '0))
        else $error("unknown cell reported a step");

endmodule

bind grid_step_height_window gshw_checker u_gshw_checker (.*);

[tb/grid_step_height_window_test.sv]
// Testbench for grid_step_height_window: drives write and query words, keeps a
// private copy of the terrain grid and registers, and checks every step-height result.
// Depends on gshw_pkg and the grid_step_height_window RTL.
module grid_step_height_window_test;
    import gshw_pkg::*;

    // grid geometry of the block as instantiated (default parameters)
    localparam int MAP_COLS    = DEF_GRID_COLS;
    localparam int MAP_ROWS    = DEF_GRID_ROWS;
    localparam int RADIUS_CAP  = DEF_MAX_RADIUS;
    // register index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int NUM_PHASES      = 9;
    localparam int WORDS_PER_PHASE = 148;
    // the longest query scans the full radius-4 window; leave room beyond it
    localparam int DRAIN_CYCLES    = 100;
    localparam int LEFTOVER_LIMIT  = 2000;

    // Scoreboard: mirrors the grid and registers, predicts the step height of
    // every accepted query and compares the results in order.
    class step_height_scoreboard;
        bit                 known_map[MAP_COLS*MAP_ROWS];
        logic signed [15:0] median_mem[MAP_COLS*MAP_ROWS];
        logic [15:0]        own_mem[MAP_COLS*MAP_ROWS];
        logic [2:0]         radius;
        logic [8:0]         width_in_use;
        logic [8:0]         height_in_use;
        out_word_t          pending_steps[$];
        int                 errors;

        function new();
            foreach (known_map[i])
                known_map[i] = 1'b0;
            radius        = RST_WINDOW_RADIUS;
            width_in_use  = RST_GRID_WIDTH;
            height_in_use = RST_GRID_HEIGHT;
            errors        = 0;
        endfunction

        function int clamp_size(logic [8:0] v, int limit);
            if (v == 0)
                return 1;
            if (int'(v) > limit)
                return limit;
            return int'(v);
        endfunction

        function int pending();
            return pending_steps.size();
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW_RADIUS: radius        = data[2:0];
                REG_GRID_WIDTH:    width_in_use  = data[8:0];
                REG_GRID_HEIGHT:   height_in_use = data[8:0];
                default: ;
            endcase
        endfunction

        // Apply an accepted word: store a cell, or queue the predicted query result.
        function void note_word(in_word_t w);
            int        cols;
            int        rows;
            int        cx;
            int        cy;
            int        idx;
            int        n;
            int        cz;
            int        r;
            int        x;
            int        y;
            int        ad;
            int        step;
            bit        in_grid;
            out_word_t want;

            cols    = clamp_size(width_in_use, MAP_COLS);
            rows    = clamp_size(height_in_use, MAP_ROWS);
            cx      = int'(w.cell_x);
            cy      = int'(w.cell_y);
            in_grid = (cx < cols) && (cy < rows);
            idx     = cy * MAP_COLS + cx;

            if (w.func == FUNC_WRITE)
            begin
                if (in_grid)
                begin
                    known_map[idx]  = w.cell_known;
                    median_mem[idx] = w.median_z;
                    own_mem[idx]    = w.own_height;
                end
                return;
            end

            want.res_x       = w.cell_x;
            want.res_y       = w.cell_y;
            want.res_known   = 1'b0;
            want.step_height = '0;
            if (in_grid && known_map[idx])
            begin
                cz   = int'(median_mem[idx]);
                r    = (int'(radius) > RADIUS_CAP) ? RADIUS_CAP : int'(radius);
                step = int'(own_mem[idx]);
                for (y = cy - r; y <= cy + r; y++)
                begin
                    if (y < 0 || y >= rows)
                        continue;
                    for (x = cx - r; x <= cx + r; x++)
                    begin
                        if (x < 0 || x >= cols)
                            continue;
                        n = y * MAP_COLS + x;
                        if (!known_map[n])
                            continue;
                        ad = int'(median_mem[n]) - cz;
                        if (ad < 0)
                            ad = -ad;
                        if (ad > step)
                            step = ad;
                    end
                end
                if (step > 65535)
                    step = 65535;
                want.res_known   = 1'b1;
                want.step_height = step[15:0];
            end
            pending_steps = {pending_steps, want};
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (pending_steps.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: x=%0d y=%0d step=%0d",
                                          got.res_x, got.res_y, got.step_height));
                return;
            end
            want = pending_steps.pop_front();
            if (got.res_x !== want.res_x)
                report_mismatch($sformatf("res_x got %0d want %0d", got.res_x, want.res_x));
            if (got.res_y !== want.res_y)
                report_mismatch($sformatf("res_y got %0d want %0d", got.res_y, want.res_y));
            if (got.res_known !== want.res_known)
                report_mismatch($sformatf("res_known got %b want %b at (%0d,%0d)",
                                          got.res_known, want.res_known, want.res_x, want.res_y));
            if (got.step_height !== want.step_height)
                report_mismatch($sformatf("step_height got %0d want %0d at (%0d,%0d)",
                                          got.step_height, want.step_height,
                                          want.res_x, want.res_y));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    in_word_t              cmd      = '0;
    logic                  done;
    out_word_t             result;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    step_height_scoreboard sb;

    grid_step_height_window uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Monitor: everything is sampled at the rising edge, before the block's own
    // updates of that edge land. Check results first, so a word accepted at the
    // same edge as a result queues behind it.
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (done === 1'b1)
                sb.check_result(result);
            if (cfg_we)
                sb.note_config(cfg_addr, cfg_data);
            if (start && busy === 1'b0)
                sb.note_word(cmd);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present a word and hold it until the block takes it. Start is left high,
    // so back-to-back words never see start drop and rise in one step.
    task automatic send_word(in_word_t w);
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Drop start for a random gap between words.
    task automatic hold_off();
        start <= 1'b0;
        repeat ($urandom_range(1, 15))
            @(posedge clk);
    endtask

    // Write one register; cfg_we stays high so writes can run back to back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Wait until every queued result is in, then let trailing writes finish and
    // make sure the block has gone idle before touching the registers.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Radius bits sit at the bottom of the data word; fill the unused top bits
    // at random since the block must ignore them.
    task automatic apply_config(int r, int w, int h, bit poke_spare);
        write_reg(REG_WINDOW_RADIUS, {6'($urandom), 3'(r)});
        write_reg(REG_GRID_WIDTH, 9'(w));
        write_reg(REG_GRID_HEIGHT, 9'(h));
        if (poke_spare)
            write_reg(REG_SPARE, 9'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic in_word_t make_cmd(logic f, int x, int y, logic k, int med, int own);
        in_word_t w;
        w.func       = f;
        w.cell_x     = 8'(x);
        w.cell_y     = 8'(y);
        w.cell_known = k;
        w.median_z   = 16'(med);
        w.own_height = 16'(own);
        return w;
    endfunction

    function automatic int clamp_dim(int v, int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Corner of the little patch that most words land in: the origin, the far
    // edge of the grid in use (so the patch hangs over it), or anywhere within it.
    function automatic logic [7:0] pick_focus(int lim);
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'((lim > 3) ? lim - 3 : 0);
            default: return 8'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // Mostly inside the patch, so windows see known neighbours; some edge
    // values and some anywhere in the full coordinate range.
    function automatic logic [7:0] pick_coord(logic [7:0] focus, int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return focus + 8'($urandom_range(0, 5));
        if (roll < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'd0;
                1:       return 8'(lim - 1);
                2:       return 8'(lim);
                default: return 8'd255;
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic in_word_t make_word(logic [7:0] fx, logic [7:0] fy, int cols, int rows);
        in_word_t w;
        int       roll;
        w.func       = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_QUERY;
        w.cell_x     = pick_coord(fx, cols);
        w.cell_y     = pick_coord(fy, rows);
        w.cell_known = ($urandom_range(0, 4) != 0);
        roll = $urandom_range(0, 9);
        case (roll)
            0:       w.median_z = 16'sh8000;
            1:       w.median_z = 16'sh7FFF;
            2, 3, 4: w.median_z = 16'($urandom);
            default: w.median_z = 16'($urandom_range(0, 4000) - 2000);
        endcase
        // small own heights let neighbour differences win the maximum
        w.own_height = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         p;
        int         i;
        int         r;
        int         w;
        int         h;
        int         cols;
        int         rows;
        int         gap_pct;
        int         waited;
        bit         spare;
        logic [7:0] fx;
        logic [7:0] fy;

        sb = new();

        // hold reset, then sit out the clearing pass
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        // Directed words at the reset settings (radius 1, full grid).
        // Unknown cell before anything was written.
        send_word(make_cmd(FUNC_QUERY, 0, 0, 1'b0, 0, 0));
        // Extreme medians side by side: the difference reaches 65535, the top of the result range.
        send_word(make_cmd(FUNC_WRITE, 0, 0, 1'b1, -32768, 0));
        send_word(make_cmd(FUNC_WRITE, 1, 0, 1'b1, 32767, 0));
        send_word(make_cmd(FUNC_WRITE, 0, 1, 1'b0, 0, 65535));
        send_word(make_cmd(FUNC_QUERY, 0, 0, 1'b0, 0, 0));
        send_word(make_cmd(FUNC_QUERY, 1, 0, 1'b0, 0, 0));
        // written but not known: still answers 0
        send_word(make_cmd(FUNC_QUERY, 0, 1, 1'b0, 0, 0));
        // far corner: window clipped at both grid edges
        send_word(make_cmd(FUNC_WRITE, 255, 255, 1'b1, 100, 65535));
        send_word(make_cmd(FUNC_WRITE, 254, 255, 1'b1, 5, 3));
        send_word(make_cmd(FUNC_WRITE, 255, 254, 1'b1, -100, 0));
        send_word(make_cmd(FUNC_QUERY, 255, 255, 1'b0, 0, 0));
        send_word(make_cmd(FUNC_QUERY, 254, 255, 1'b0, 0, 0));
        send_word(make_cmd(FUNC_QUERY, 255, 254, 1'b0, 0, 0));
        // knock out a neighbour: its median must no longer count
        send_word(make_cmd(FUNC_WRITE, 1, 0, 1'b0, 0, 0));
        send_word(make_cmd(FUNC_QUERY, 0, 0, 1'b0, 0, 0));
        send_word(make_cmd(FUNC_WRITE, 2, 2, 1'b1, 32767, 32768));
        send_word(make_cmd(FUNC_QUERY, 2, 2, 1'b1, -1, 65535));
        // never written, far from anything
        send_word(make_cmd(FUNC_QUERY, 128, 128, 1'b1, 0, 0));

        // Random phases, one register setting each; the last runs without gaps.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            spare = 1'b0;
            case (p)
                0: begin r = 1; w = 256; h = 256; end
                1: begin r = 0; w = 256; h = 256; end
                2: begin r = 4; w = 256; h = 256; end
                3: begin r = 7; w = 511; h = 511; end
                4: begin r = 2; w = 0;   h = 1; spare = 1'b1; end
                5: begin r = 3; w = 17;  h = 9; end
                6: begin r = 4; w = 1;   h = 256; end
                7: begin r = 1; w = 256; h = 3; end
                default:
                begin
                    r = $urandom_range(0, 7);
                    w = $urandom_range(0, 511);
                    h = $urandom_range(0, 511);
                end
            endcase
            apply_config(r, w, h, spare);
            cols = clamp_dim(w, MAP_COLS);
            rows = clamp_dim(h, MAP_ROWS);

            if (p == NUM_PHASES - 1)
                gap_pct = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 30;
                endcase
            end

            fx = 8'd0;
            fy = 8'd0;
            for (i = 0; i < WORDS_PER_PHASE; i++)
            begin
                // move the patch now and then to spread the writes
                if (i % 37 == 0)
                begin
                    fx = pick_focus(cols);
                    fy = pick_focus(rows);
                end
                if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                    hold_off();
                send_word(make_word(fx, fy, cols, rows));
            end
        end

        // Drain: wait for outstanding results within a bound, then give any
        // stray strobe time to show up.
        start  <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < LEFTOVER_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run, clearing pass included.
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
